>>> sv/ows_pkg.sv
// ----------------------------------------------------------------------------
// ows_pkg
// Shared types, register indexes, defaults and the tick counter helper of
// the one-wire bus master sequencer.
// ----------------------------------------------------------------------------
package ows_pkg;

  localparam int CFG_W    = 10;
  localparam int NUM_CFG  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int READ_GAP_US_DEF = 15;

  typedef logic [CFG_W-1:0] cfg_val_t;
  typedef cfg_val_t cfg_arr_t [NUM_CFG];

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE  = 3'd7;

  localparam cfg_val_t CFG_DEFAULT [NUM_CFG] = '{
    10'd500, 10'd45, 10'd470, 10'd5, 10'd80, 10'd100, 10'd2, 10'd15
  };

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_RST_LOW     = 4'd1,
    PH_RST_WAIT    = 4'd2,
    PH_RST_RECOVER = 4'd3,
    PH_WR_LOW      = 4'd4,
    PH_WR_SLOT     = 4'd5,
    PH_WR_REL      = 4'd6,
    PH_WR_GAP      = 4'd7,
    PH_RD_LOW      = 4'd8,
    PH_RD_WAIT     = 4'd9,
    PH_RD_GAP      = 4'd10
  } phase_t;

  typedef struct packed {
    logic       rejected;
    logic [7:0] read_data;
    logic       presence;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

  typedef struct packed {
    logic     done;
    cfg_val_t count;
  } cnt_step_t;

  // one tick of a phase timer; a zero length behaves as one
  function automatic cnt_step_t count_step(cfg_val_t count, cfg_val_t len);
    cnt_step_t r;
    cfg_val_t  inc;
    inc = count + cfg_val_t'(1);
    if ((inc >= len) || (inc == '0)) begin
      r.done  = 1'b1;
      r.count = '0;
    end else begin
      r.done  = 1'b0;
      r.count = inc;
    end
    return r;
  endfunction

endpackage

>>> sv/ows_cfg_regs.sv
// ----------------------------------------------------------------------------
// ows_cfg_regs
// Timing register file, written one word at a time from the config channel.
// ----------------------------------------------------------------------------
module ows_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ows_pkg::CFG_IDX_W-1:0] wr_index,
  input  ows_pkg::cfg_val_t             wr_data,
  output ows_pkg::cfg_arr_t             cfg
);

  ows_pkg::cfg_arr_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ows_pkg::CFG_DEFAULT;
    end else if (wr_en) begin
      cfg_r[wr_index] <= wr_data;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/ows_engine.sv
// ----------------------------------------------------------------------------
// ows_engine
// Sequencer state and the single-pass update for one accepted word.
// ----------------------------------------------------------------------------
module ows_engine #(
  parameter int READ_GAP_US = ows_pkg::READ_GAP_US_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  logic [1:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic              line_level,
  input  ows_pkg::cfg_arr_t cfg,
  output ows_pkg::res_t     res
);

  localparam int GW = $clog2(READ_GAP_US + 1);
  localparam logic [GW-1:0] GAP_LEN = GW'(READ_GAP_US);

  ows_pkg::phase_t   phase_r, phase_nxt;
  ows_pkg::cfg_val_t tick_r, tick_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              pres_r, pres_nxt;
  logic [GW-1:0]     gap_r, gap_nxt;
  logic [7:0]        last_r, last_nxt;
  logic              done, rej, drive;

  always_comb begin
    ows_pkg::cnt_step_t cs;
    logic [GW-1:0]      g;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    gap_nxt   = gap_r;
    last_nxt  = last_r;
    done      = 1'b0;
    rej       = 1'b0;
    cs        = '0;
    g         = gap_r + GW'(1);
    if (opcode != ows_pkg::OP_TICK) begin
      if (phase_r != ows_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_nxt = '0;
        bit_nxt  = '0;
        unique case (opcode)
          ows_pkg::OP_RESET: phase_nxt = ows_pkg::PH_RST_LOW;
          ows_pkg::OP_WRITE: begin
            shift_nxt = data_byte;
            phase_nxt = ows_pkg::PH_WR_LOW;
          end
          default: begin
            shift_nxt = '0;
            phase_nxt = ows_pkg::PH_RD_LOW;
          end
        endcase
      end
    end else begin
      unique case (phase_r)
        ows_pkg::PH_RST_LOW: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_RESET_LOW]);
          tick_nxt = cs.count;
          if (cs.done) phase_nxt = ows_pkg::PH_RST_WAIT;
        end
        ows_pkg::PH_RST_WAIT: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_PRESENCE_WAIT]);
          tick_nxt = cs.count;
          if (cs.done) begin
            pres_nxt  = ~line_level;
            phase_nxt = ows_pkg::PH_RST_RECOVER;
          end
        end
        ows_pkg::PH_RST_RECOVER: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_RESET_RECOVER]);
          tick_nxt = cs.count;
          if (cs.done) begin
            phase_nxt = ows_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        ows_pkg::PH_WR_LOW: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_WRITE_LOW]);
          tick_nxt = cs.count;
          if (cs.done) phase_nxt = ows_pkg::PH_WR_SLOT;
        end
        ows_pkg::PH_WR_SLOT: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_WRITE_SLOT]);
          tick_nxt = cs.count;
          if (cs.done) begin
            if (bit_r == 3'd7) begin
              if (cfg[ows_pkg::CFG_BYTE_GAP] == '0) begin
                phase_nxt = ows_pkg::PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = ows_pkg::PH_WR_GAP;
              end
            end else begin
              bit_nxt   = bit_r + 3'd1;
              shift_nxt = {1'b0, shift_r[7:1]};
              phase_nxt = ows_pkg::PH_WR_REL;
            end
          end
        end
        ows_pkg::PH_WR_REL: begin
          tick_nxt  = '0;
          phase_nxt = ows_pkg::PH_WR_LOW;
        end
        ows_pkg::PH_WR_GAP: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_BYTE_GAP]);
          tick_nxt = cs.count;
          if (cs.done) begin
            phase_nxt = ows_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        ows_pkg::PH_RD_LOW: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_READ_LOW]);
          tick_nxt = cs.count;
          if (cs.done) phase_nxt = ows_pkg::PH_RD_WAIT;
        end
        ows_pkg::PH_RD_WAIT: begin
          cs = ows_pkg::count_step(tick_r, cfg[ows_pkg::CFG_READ_SAMPLE]);
          tick_nxt = cs.count;
          if (cs.done) begin
            if (line_level) shift_nxt[bit_r] = 1'b1;
            gap_nxt   = '0;
            phase_nxt = ows_pkg::PH_RD_GAP;
          end
        end
        ows_pkg::PH_RD_GAP: begin
          gap_nxt = g;
          if (g >= GAP_LEN) begin
            gap_nxt = '0;
            if (bit_r == 3'd7) begin
              last_nxt  = shift_r;
              phase_nxt = ows_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              tick_nxt  = '0;
              phase_nxt = ows_pkg::PH_RD_LOW;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (phase_nxt)
      ows_pkg::PH_RST_LOW,
      ows_pkg::PH_WR_LOW,
      ows_pkg::PH_RD_LOW:  drive = 1'b1;
      ows_pkg::PH_WR_SLOT: drive = ~shift_nxt[0];
      default:             drive = 1'b0;
    endcase
  end

  always_comb begin
    res.drive_low = drive;
    res.busy_res  = (phase_nxt != ows_pkg::PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = last_nxt;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ows_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      gap_r   <= '0;
      last_r  <= '0;
    end else if (item_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      gap_r   <= gap_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

>>> sv/ows_outbuf.sv
// ----------------------------------------------------------------------------
// ows_outbuf
// Result register with a skid stage, so the input side keeps taking words
// while a result waits.
// ----------------------------------------------------------------------------
module ows_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ows_pkg::res_t wr_data,
  output logic          wr_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ows_pkg::res_t out_data
);

  logic          main_v_r, skid_v_r;
  ows_pkg::res_t main_r, skid_r;
  logic          pop;

  assign pop       = main_v_r & out_ready;
  assign wr_ready  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= wr_en;
      end
    end else if (!main_v_r) begin
      main_v_r <= wr_en;
    end else if (wr_en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_v_r ? skid_r : wr_data;
    end else if (!main_v_r) begin
      main_r <= wr_data;
    end else if (wr_en) begin
      skid_r <= wr_data;
    end
  end

endmodule

>>> sv/onewire_master_sequencer_core.sv
// ----------------------------------------------------------------------------
// onewire_master_sequencer_core
// One-wire bus master: reset/presence, byte write and byte read sequencing.
// ----------------------------------------------------------------------------
// Each input word is a 1 us tick carrying the sampled bus level, or a
// command (reset, write byte, read byte) selected by in_tuser. Every word
// yields exactly one result word with the bus drive and status. One word is
// taken per clock: the whole update is one pass through the sequencer logic
// into the result register, and a skid stage keeps in_tready high while a
// single result is stalled. Commands while busy are flagged rejected. Users
// must write timing registers via the cfg channel while idle (not enforced).
// ----------------------------------------------------------------------------
module onewire_master_sequencer_core #(
  parameter int READ_GAP_US = ows_pkg::READ_GAP_US_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: [7:0] data_byte, [8] line_level, [15:9] zero
  input  logic [15:0]                   in_tdata,
  // tuser: [1:0] opcode
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  //        [11:4] read_data, [12] rejected, [15:13] zero
  output logic [15:0]                   out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ows_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ows_pkg::CFG_W-1:0]     cfg_data
);

  ows_pkg::cfg_arr_t cfg;
  ows_pkg::res_t     res, res_q;
  logic              item_en;

  assign cfg_ready = 1'b1;
  assign item_en   = in_tvalid & in_tready;

  ows_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ows_engine #(
    .READ_GAP_US (READ_GAP_US)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (item_en),
    .opcode     (in_tuser),
    .data_byte  (in_tdata[7:0]),
    .line_level (in_tdata[8]),
    .cfg        (cfg),
    .res        (res)
  );

  ows_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (item_en),
    .wr_data   (res),
    .wr_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_q)
  );

  assign out_tdata = {3'b000, res_q};

endmodule
